// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the viewport window cache checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define VWCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define VWCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vwcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Viewport window cache control package
// Field widths, register indexes, status codes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vwcc_pkg;

    // Field widths
    localparam int COORD_BITS  = 21;
    localparam int DIM_BITS    = 20;
    localparam int MARGIN_BITS = 16;
    localparam int ZOOM_BITS   = 9;
    localparam int ROT_BITS    = 2;
    localparam int IDX_BITS    = 3;
    localparam int TDATA_BITS  = 96;

    // Register reset values
    localparam logic [DIM_BITS-1:0]    IMAGE_DIM_RESET   = DIM_BITS'(1);
    localparam logic [MARGIN_BITS-1:0] GROW_MARGIN_RESET = MARGIN_BITS'(1024);
    localparam logic [ZOOM_BITS-1:0]   WIN_ZOOM_RESET    = ZOOM_BITS'(1);

    // Configuration register indexes
    typedef logic [IDX_BITS-1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_ORIGIN_X     = 3'd0;
    localparam cfg_idx_t CFG_ORIGIN_Y     = 3'd1;
    localparam cfg_idx_t CFG_ROTATION     = 3'd2;
    localparam cfg_idx_t CFG_IMAGE_WIDTH  = 3'd3;
    localparam cfg_idx_t CFG_IMAGE_HEIGHT = 3'd4;
    localparam cfg_idx_t CFG_GROW_MARGIN  = 3'd5;

    // Result status codes
    typedef logic [1:0] status_t;
    localparam status_t ST_NONE  = 2'd0;
    localparam status_t ST_HIT   = 2'd1;
    localparam status_t ST_LOAD  = 2'd2;
    localparam status_t ST_SMALL = 2'd3;

    // One axis of a window: start and extent
    typedef struct packed {
        logic [DIM_BITS-1:0] pos;
        logic [DIM_BITS-1:0] ext;
    } span_t;

    // Result item held in the output register
    typedef struct packed {
        status_t              status;
        logic [DIM_BITS-1:0]  u0;
        logic [DIM_BITS-1:0]  v0;
        logic [DIM_BITS-1:0]  w;
        logic [DIM_BITS-1:0]  h;
        logic [ZOOM_BITS-1:0] factor;
    } result_t;

endpackage

// ===== rtl/viewport_window_cache_control_unit.sv =====
// ----------------------------------------------------------------------------
// Viewport window cache control unit
// Clips viewport requests to the image and keeps the cached window up to date.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_* stream (two corners and a zoom factor). Each
//   request yields exactly one result on the m_* stream: a status code in
//   m_tuser and the cached window after the request in m_tdata.
//   Registers are written through cfg_wen / cfg_index / cfg_wdata while no
//   request is in flight; indexes past the last register are ignored.
//   Flow: an accepted request is held in the input register, evaluated and
//   presented on m_tvalid once the output register loads its result.
//   Throughput: one request per cycle; the clip, hit test and window grow
//   form one combinational pass between input and output registers, and the
//   window state is updated at the same edge that loads the result.
//   When m_tready is low the result holds and one more request can wait in
//   the input register; s_tready then drops until the result is taken.
//   Reset clears the valid bits of both pipeline registers, the window state
//   (nothing loaded, zoom one) and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module viewport_window_cache_control_unit
    import vwcc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration write port
    input  logic                    cfg_wen,
    input  logic [IDX_BITS-1:0]     cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_wdata,
    // Request stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // corner_x0 [20:0], corner_y0 [41:21], corner_x1 [62:42],
    // corner_y1 [83:63], zoom_factor [92:84], zero [95:93]
    input  logic [TDATA_BITS-1:0]   s_tdata,
    // Result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // window_u0 [19:0], window_v0 [39:20], window_w [59:40],
    // window_h [79:60], window_factor [88:80], zero [95:89]
    output logic [TDATA_BITS-1:0]   m_tdata,
    // status [1:0]
    output logic [1:0]              m_tuser
);

    // Configuration registers
    logic [COORD_BITS-1:0]  origin_x_reg;
    logic [COORD_BITS-1:0]  origin_y_reg;
    logic [ROT_BITS-1:0]    rotation_reg;
    logic [DIM_BITS-1:0]    image_width_reg;
    logic [DIM_BITS-1:0]    image_height_reg;
    logic [MARGIN_BITS-1:0] grow_margin_reg;

    // Window state
    logic [DIM_BITS-1:0]    win_left_reg, win_left_next;
    logic [DIM_BITS-1:0]    win_top_reg, win_top_next;
    logic [DIM_BITS-1:0]    win_width_reg, win_width_next;
    logic [DIM_BITS-1:0]    win_height_reg, win_height_next;
    logic [ZOOM_BITS-1:0]   win_zoom_reg, win_zoom_next;
    logic                   win_loaded_reg, win_loaded_next;

    // Pipeline registers
    logic                   in_valid_reg;
    logic [COORD_BITS-1:0]  x0_reg, y0_reg, x1_reg, y1_reg;
    logic [ZOOM_BITS-1:0]   zoom_reg;
    logic                   out_valid_reg;
    result_t                out_reg;
    result_t                out_next;

    // Datapath
    logic                   advance;
    logic                   swap;
    logic [DIM_BITS-1:0]    nx, ny;
    logic [COORD_BITS:0]    dx0, dy0, dx1, dy1;
    logic [COORD_BITS-1:0]  su_full, sv_full;
    logic [DIM_BITS-1:0]    su, sv, eu, ev, w, h;
    logic                   miss_region;
    logic                   hit;
    span_t                  grow_u, grow_v;
    logic                   too_small;

    // Grow a region by the margin and clamp it to the image size
    function automatic span_t grow_axis(
        input logic [DIM_BITS-1:0]    start,
        input logic [DIM_BITS-1:0]    len,
        input logic [DIM_BITS-1:0]    size,
        input logic [MARGIN_BITS-1:0] margin
    );
        logic [DIM_BITS-1:0]   m;
        logic [DIM_BITS-1:0]   p;
        logic [DIM_BITS+1:0]   e;
        logic [DIM_BITS+1:0]   sum;
        span_t                 r;
        m   = DIM_BITS'(margin);
        p   = (start >= m) ? start - m : '0;
        e   = (DIM_BITS+2)'(start - p) + (DIM_BITS+2)'(len) + (DIM_BITS+2)'(margin);
        sum = (DIM_BITS+2)'(p) + e;
        if (sum >= (DIM_BITS+2)'(size))
        begin
            e = (DIM_BITS+2)'(size - p);
        end
        r.pos = p;
        r.ext = e[DIM_BITS-1:0];
        return r;
    endfunction

    // Handshake: output register frees up when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            rotation_reg     <= '0;
            image_width_reg  <= IMAGE_DIM_RESET;
            image_height_reg <= IMAGE_DIM_RESET;
            grow_margin_reg  <= GROW_MARGIN_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_ORIGIN_X:     origin_x_reg     <= cfg_wdata;
                CFG_ORIGIN_Y:     origin_y_reg     <= cfg_wdata;
                CFG_ROTATION:     rotation_reg     <= cfg_wdata[ROT_BITS-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[DIM_BITS-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[DIM_BITS-1:0];
                CFG_GROW_MARGIN:  grow_margin_reg  <= cfg_wdata[MARGIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            x0_reg   <= s_tdata[20:0];
            y0_reg   <= s_tdata[41:21];
            x1_reg   <= s_tdata[62:42];
            y1_reg   <= s_tdata[83:63];
            zoom_reg <= s_tdata[92:84];
        end
    end

    // Clip to the displayed image; rotations 1 and 3 swap the axes
    always_comb
    begin
        swap = rotation_reg[0];
        nx   = swap ? image_height_reg : image_width_reg;
        ny   = swap ? image_width_reg : image_height_reg;

        dx0 = {x0_reg[COORD_BITS-1], x0_reg} - {origin_x_reg[COORD_BITS-1], origin_x_reg};
        dy0 = {y0_reg[COORD_BITS-1], y0_reg} - {origin_y_reg[COORD_BITS-1], origin_y_reg};
        dx1 = {x1_reg[COORD_BITS-1], x1_reg} - {origin_x_reg[COORD_BITS-1], origin_x_reg};
        dy1 = {y1_reg[COORD_BITS-1], y1_reg} - {origin_y_reg[COORD_BITS-1], origin_y_reg};

        // start clamps at the origin
        su_full = (!dx0[COORD_BITS] && (dx0 != '0)) ? dx0[COORD_BITS-1:0] : '0;
        sv_full = (!dy0[COORD_BITS] && (dy0 != '0)) ? dy0[COORD_BITS-1:0] : '0;
        su      = su_full[DIM_BITS-1:0];
        sv      = sv_full[DIM_BITS-1:0];

        miss_region = dx1[COORD_BITS] || dy1[COORD_BITS]
                   || (su_full > {1'b0, nx}) || (sv_full > {1'b0, ny});

        // end clamps at the image size
        eu = (dx1[COORD_BITS-1:0] > {1'b0, nx}) ? nx : dx1[DIM_BITS-1:0];
        ev = (dy1[COORD_BITS-1:0] > {1'b0, ny}) ? ny : dy1[DIM_BITS-1:0];

        // inverted range counts as zero size
        w = (eu >= su) ? eu - su : '0;
        h = (ev >= sv) ? ev - sv : '0;
    end

    // Hit test against the cached window
    assign hit = win_loaded_reg && (su >= win_left_reg) && (sv >= win_top_reg)
              && (zoom_reg == win_zoom_reg)
              && ((DIM_BITS+1)'(su) + (DIM_BITS+1)'(w)
                  <= (DIM_BITS+1)'(win_left_reg) + (DIM_BITS+1)'(win_width_reg))
              && ((DIM_BITS+1)'(sv) + (DIM_BITS+1)'(h)
                  <= (DIM_BITS+1)'(win_top_reg) + (DIM_BITS+1)'(win_height_reg));

    // New window on a miss
    assign grow_u    = grow_axis(su, w, nx, grow_margin_reg);
    assign grow_v    = grow_axis(sv, h, ny, grow_margin_reg);
    assign too_small = (zoom_reg == '0)
                    || (grow_u.ext < DIM_BITS'(zoom_reg))
                    || (grow_v.ext < DIM_BITS'(zoom_reg));

    // Next window state and result
    always_comb
    begin
        win_left_next   = win_left_reg;
        win_top_next    = win_top_reg;
        win_width_next  = win_width_reg;
        win_height_next = win_height_reg;
        win_zoom_next   = win_zoom_reg;
        win_loaded_next = win_loaded_reg;
        out_next.status = ST_NONE;

        if (miss_region)
        begin
            out_next.status = ST_NONE;
        end
        else if (hit)
        begin
            out_next.status = ST_HIT;
        end
        else
        begin
            win_left_next   = grow_u.pos;
            win_width_next  = grow_u.ext;
            win_top_next    = grow_v.pos;
            win_height_next = grow_v.ext;
            win_zoom_next   = zoom_reg;
            if (too_small)
            begin
                out_next.status = ST_SMALL;
            end
            else
            begin
                win_loaded_next = 1'b1;
                out_next.status = ST_LOAD;
            end
        end

        out_next.u0     = win_left_next;
        out_next.v0     = win_top_next;
        out_next.w      = win_width_next;
        out_next.h      = win_height_next;
        out_next.factor = win_zoom_next;
    end

    // Window state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= '0;
            win_top_reg    <= '0;
            win_width_reg  <= '0;
            win_height_reg <= '0;
            win_zoom_reg   <= WIN_ZOOM_RESET;
            win_loaded_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                win_left_reg   <= win_left_next;
                win_top_reg    <= win_top_next;
                win_width_reg  <= win_width_next;
                win_height_reg <= win_height_next;
                win_zoom_reg   <= win_zoom_next;
                win_loaded_reg <= win_loaded_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {7'b0, out_reg.factor, out_reg.h, out_reg.w, out_reg.v0, out_reg.u0};

endmodule

// ===== rtl/vwcc_checker.sv =====
// ----------------------------------------------------------------------------
// Viewport window cache control checker
// Port-level checks on status consistency, stall behavior and backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vwcc_checker
    import vwcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [TDATA_BITS-1:0] m_tdata,
    input  logic [1:0]            m_tuser
);

    logic [DIM_BITS-1:0]  res_w;
    logic [DIM_BITS-1:0]  res_h;
    logic [ZOOM_BITS-1:0] res_factor;
    logic                 fits;

    assign res_w      = m_tdata[59:40];
    assign res_h      = m_tdata[79:60];
    assign res_factor = m_tdata[88:80];
    assign fits       = (res_factor != '0)
                     && (res_w >= DIM_BITS'(res_factor))
                     && (res_h >= DIM_BITS'(res_factor));

    // A stalled result holds
    `VWCC_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // A reload always leaves a window of at least one zoomed pixel
    `VWCC_ASSERT_NOW(a_load_fits, clk, rst_n, m_tvalid && (m_tuser == ST_LOAD),
        fits, "reload reported with a window below the zoom")

    // Too small means the window really is below one zoomed pixel
    `VWCC_ASSERT_NOW(a_small_fits, clk, rst_n, m_tvalid && (m_tuser == ST_SMALL),
        !fits, "window too small reported on a window that fits")

    // Requests are only held off while a result is stalled
    `VWCC_ASSERT_NOW(a_ready, clk, rst_n, !s_tready,
        m_tvalid && !m_tready, "request side stalled without output backpressure")

endmodule

bind viewport_window_cache_control_unit vwcc_checker u_vwcc_checker (.*);
